// ----- design/ktce_pkg.sv -----
`default_nettype none
package ktce_pkg;

    typedef enum logic [2:0] {
        OP_OPEN   = 3'd0,
        OP_CLOSE  = 3'd1,
        OP_SUBMIT = 3'd2,
        OP_FRAME  = 3'd3,
        OP_TICK   = 3'd4
    } op_e;

    typedef enum logic [2:0] {
        KIND_MEM_WRITE  = 3'd0,
        KIND_MEM_READ   = 3'd1,
        KIND_PROP_WRITE = 3'd2,
        KIND_PROP_READ  = 3'd3
    } kind_e;

    typedef enum logic [2:0] {
        FT_ACK     = 3'd0,
        FT_NAK     = 3'd1,
        FT_DISC    = 3'd2,
        FT_CONNECT = 3'd3,
        FT_DATA    = 3'd4
    } ftype_e;

    typedef enum logic [3:0] {
        EV_CONNECT      = 4'd0,
        EV_DISCONNECT   = 4'd1,
        EV_REQUEST      = 4'd2,
        EV_ACK          = 4'd3,
        EV_OPENED       = 4'd4,
        EV_CLOSED       = 4'd5,
        EV_IDLE         = 4'd6,
        EV_NAK_LIMIT    = 4'd7,
        EV_NO_ACK       = 4'd8,
        EV_DATA         = 4'd9,
        EV_QUEUE_FULL   = 4'd10,
        EV_FRAME_STATUS = 4'd11
    } ev_e;

    localparam logic [0:0] CFG_MAX_RETRIES = 1'b0;
    localparam logic [0:0] CFG_ACK_TIMEOUT = 1'b1;
    localparam logic [3:0] MAX_RETRIES_RST = 4'd3;
    localparam logic [15:0] ACK_TIMEOUT_RST = 16'd3000;

    typedef struct packed {
        logic [2:0]  operation;
        logic [15:0] peer_addr;
        logic [2:0]  request_kind;
        logic [15:0] mem_addr;
        logic [7:0]  item_count;
        logic [7:0]  object_index;
        logic [7:0]  property_id;
        logic [11:0] start_index;
        logic [7:0]  payload_tag;
        logic [2:0]  frame_type;
        logic        frame_is_group;
        logic [3:0]  frame_seq;
    } in_word_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [15:0] mem;
        logic [7:0]  count;
        logic [7:0]  obj;
        logic [7:0]  prop;
        logic [11:0] start;
        logic [7:0]  tag;
    } req_t;

    localparam int REQ_W = $bits(req_t);

    typedef struct packed {
        logic [3:0]  event_res;
        logic [15:0] dest_addr;
        logic [2:0]  out_kind;
        logic [15:0] out_mem_addr;
        logic [7:0]  out_count;
        logic [7:0]  out_object_index;
        logic [7:0]  out_property_id;
        logic [11:0] out_start_index;
        logic [7:0]  out_payload_tag;
        logic [3:0]  out_seq;
        logic        frame_claimed;
        logic        last;
    } out_word_t;

    // classified command handed from front to back
    typedef struct packed {
        logic [2:0]  operation;
        logic [15:0] peer_addr;
        req_t        req;
        logic [2:0]  frame_type;
        logic        frame_is_group;
        logic [3:0]  frame_seq;
    } cmd_t;

    localparam int CMD_W = $bits(cmd_t);

endpackage
`default_nettype wire

// ----- design/knx_transport_connection_engine.sv -----
`default_nettype none
// An accepted word is registered in the front end's two-entry buffer and is taken into the back
// end's command register when the back end is idle; an item writes up to four result words.
// The back end takes the next item only once it is idle and the result buffer has drained, so
// items do not overlap; it writes at most one result word a cycle.
// Reset: async active low; connection closed, queue empty, registers 3 and 3000.
module knx_transport_connection_engine #(
    parameter int QUEUE_DEPTH = 16
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                push,
    output logic                     full,
    input  wire ktce_pkg::in_word_t  in_word,
    output logic                     empty,
    input  wire logic                pop,
    output ktce_pkg::out_word_t      out_word,
    input  wire logic                cfg_we,
    input  wire logic                cfg_index,
    input  wire logic [15:0]         cfg_data
);
    import ktce_pkg::*;

    logic cmd_valid, cmd_pop;
    cmd_t cmd;

    ktce_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .full     (full),
        .in_word  (in_word),
        .cmd_valid(cmd_valid),
        .cmd_pop  (cmd_pop),
        .cmd      (cmd)
    );

    ktce_back #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .cmd_valid(cmd_valid),
        .cmd_pop  (cmd_pop),
        .cmd      (cmd),
        .empty    (empty),
        .pop      (pop),
        .out_word (out_word)
    );
endmodule
`default_nettype wire

// ----- design/ktce_ram.sv -----
`default_nettype none
module ktce_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

// ----- design/ktce_front.sv -----
`default_nettype none
module ktce_front (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push,
    output logic                    full,
    input  wire ktce_pkg::in_word_t in_word,
    output logic                    cmd_valid,
    input  wire logic               cmd_pop,
    output ktce_pkg::cmd_t          cmd
);
    import ktce_pkg::*;

    cmd_t cmd_in;
    cmd_t slot_reg [2];
    logic [1:0] cnt_reg, cnt_next;
    logic wp_reg, rp_reg;
    logic acc;

    always_comb
    begin
        cmd_in = '0;
        cmd_in.operation = in_word.operation;
        cmd_in.peer_addr = in_word.peer_addr;
        cmd_in.frame_type = in_word.frame_type;
        cmd_in.frame_is_group = in_word.frame_is_group;
        cmd_in.frame_seq = in_word.frame_seq;
        cmd_in.req.kind = in_word.request_kind;
        case (in_word.request_kind)
            KIND_MEM_WRITE:
            begin
                cmd_in.req.mem = in_word.mem_addr;
                cmd_in.req.tag = in_word.payload_tag;
            end
            KIND_MEM_READ:
            begin
                cmd_in.req.mem = in_word.mem_addr;
                cmd_in.req.count = in_word.item_count;
            end
            KIND_PROP_WRITE, KIND_PROP_READ:
            begin
                cmd_in.req.count = in_word.item_count;
                cmd_in.req.obj = in_word.object_index;
                cmd_in.req.prop = in_word.property_id;
                cmd_in.req.start = in_word.start_index;
                if (in_word.request_kind == KIND_PROP_WRITE)
                begin
                    cmd_in.req.tag = in_word.payload_tag;
                end
            end
            default: ;
        endcase
    end

    assign full = (cnt_reg == 2'd2);
    assign acc = push && !full;
    assign cmd_valid = (cnt_reg != 2'd0);
    assign cmd = slot_reg[rp_reg];
    assign cnt_next = cnt_reg + {1'b0, acc} - {1'b0, cmd_pop};

    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            slot_reg[wp_reg] <= cmd_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            wp_reg <= 1'b0;
            rp_reg <= 1'b0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (acc)
            begin
                wp_reg <= !wp_reg;
            end
            if (cmd_pop)
            begin
                rp_reg <= !rp_reg;
            end
        end
    end
endmodule
`default_nettype wire

// ----- design/ktce_back.sv -----
`default_nettype none
module ktce_back #(
    parameter int QUEUE_DEPTH = 16
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                cfg_we,
    input  wire logic                cfg_index,
    input  wire logic [15:0]         cfg_data,
    input  wire logic                cmd_valid,
    output logic                     cmd_pop,
    input  wire ktce_pkg::cmd_t      cmd,
    output logic                     empty,
    input  wire logic                pop,
    output ktce_pkg::out_word_t      out_word
);
    import ktce_pkg::*;

    localparam int QA = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QF = $clog2(QUEUE_DEPTH + 1);
    localparam logic [QF-1:0] QFULL = QF'(QUEUE_DEPTH);
    localparam logic [QA-1:0] QLAST = QA'(QUEUE_DEPTH - 1);

    typedef enum logic [1:0] {S_IDLE, S_RUN, S_FETCH, S_READ} state_e;

    state_e state_reg;
    logic [3:0] max_retries_reg;
    logic [15:0] ack_timeout_reg;
    logic open_reg, awaiting_reg;
    logic [15:0] peer_reg, timer_reg;
    logic [3:0] sseq_reg, rseq_reg, iseq_reg;
    logic [4:0] retry_reg;
    req_t inflight_reg;
    logic [QA-1:0] head_reg;
    logic [QF-1:0] fill_reg;
    cmd_t cur_reg;
    logic [2:0] step_reg;
    logic claim_reg;

    out_word_t obuf_reg [4];
    logic [1:0] orp_reg, owp_reg;
    logic [2:0] ocnt_reg;

    logic ram_we;
    logic [QA-1:0] ram_waddr, ram_raddr;
    logic [REQ_W-1:0] ram_rdata;

    ktce_ram #(.WIDTH(REQ_W), .DEPTH(1 << QA)) u_queue (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(cur_reg.req),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    function automatic logic [QA-1:0] qinc(input logic [QA-1:0] a);
        qinc = (a == QLAST) ? '0 : a + 1'b1;
    endfunction

    function automatic logic [QA-1:0] qadd(input logic [QA-1:0] a, input logic [QF-1:0] f);
        logic [QF:0] s;
        s = {1'b0, QF'(a)} + {1'b0, f};
        if (s >= {1'b0, QFULL})
        begin
            s = s - {1'b0, QFULL};
        end
        qadd = s[QA-1:0];
    endfunction

    function automatic out_word_t mk(input logic [3:0] ev, input logic [15:0] dst,
                                      input logic [3:0] sq, input logic cl);
        out_word_t w;
        w = '0;
        w.event_res = ev;
        w.dest_addr = dst;
        w.out_seq = sq;
        w.frame_claimed = cl;
        mk = w;
    endfunction

    logic [15:0] tload;
    logic claim;
    logic claim_now;
    logic ack_ok;
    logic [4:0] retry_inc;

    assign tload = (ack_timeout_reg == 16'd0) ? 16'd1 : ack_timeout_reg;
    assign claim = open_reg && !cur_reg.frame_is_group &&
                   (cur_reg.peer_addr == peer_reg || cur_reg.peer_addr == 16'd0) &&
                   (cur_reg.frame_type <= FT_DATA);
    assign claim_now = (step_reg == 3'd0) ? claim : claim_reg;
    assign ack_ok = awaiting_reg && cur_reg.frame_seq == iseq_reg;
    assign retry_inc = retry_reg + 5'd1;

    assign empty = (ocnt_reg == 3'd0);
    assign out_word = obuf_reg[orp_reg];
    // output buffer must be empty before an item runs
    assign cmd_pop = (state_reg == S_IDLE) && cmd_valid && empty;
    assign ram_raddr = head_reg;
    assign ram_waddr = qadd(head_reg, fill_reg);
    assign ram_we = (state_reg == S_RUN) && (step_reg == 3'd0) &&
                    cur_reg.operation == OP_SUBMIT && open_reg && fill_reg != QFULL;

    // per-item emission: up to 4 words written, one per cycle
    logic em;
    out_word_t emw;
    logic done;

    always_ff @(posedge clk)
    begin
        if (em)
        begin
            obuf_reg[owp_reg] <= emw;
        end
    end

    always_comb
    begin
        emw = '0;
        em = 1'b0;
        done = 1'b0;
        if (state_reg == S_FETCH)
        begin
            em = 1'b1;
            emw = mk(EV_REQUEST, peer_reg, sseq_reg, 1'b0);
            emw.out_kind = ram_rdata[REQ_W-1 -: 3];
            {emw.out_kind, emw.out_mem_addr, emw.out_count, emw.out_object_index,
             emw.out_property_id, emw.out_start_index, emw.out_payload_tag} = ram_rdata;
            emw.last = (cur_reg.operation != OP_FRAME);
            done = 1'b1;
        end
        else if (state_reg == S_RUN)
        begin
            case (cur_reg.operation)
                OP_OPEN:
                begin
                    if (open_reg && peer_reg == cur_reg.peer_addr)
                    begin
                        done = 1'b1;
                    end
                    else if (open_reg)
                    begin
                        em = 1'b1;
                        emw = mk(EV_DISCONNECT, peer_reg, 4'd0, 1'b0);
                    end
                    else
                    begin
                        em = 1'b1;
                        if (step_reg[0] == 1'b0)
                        begin
                            emw = mk(EV_CONNECT, cur_reg.peer_addr, 4'd0, 1'b0);
                        end
                        else
                        begin
                            emw = mk(EV_OPENED, 16'd0, 4'd0, 1'b0);
                            emw.last = 1'b1;
                            done = 1'b1;
                        end
                    end
                end
                OP_CLOSE:
                begin
                    if (open_reg)
                    begin
                        em = 1'b1;
                        emw = mk(EV_DISCONNECT, peer_reg, 4'd0, 1'b0);
                    end
                    else if (step_reg == 3'd0)
                    begin
                        done = 1'b1;
                    end
                    else
                    begin
                        em = 1'b1;
                        emw = mk(EV_CLOSED, 16'd0, 4'd0, 1'b0);
                        if (cur_reg.frame_type != FT_CONNECT)
                        begin
                            emw.last = 1'b1;
                            done = 1'b1;
                        end
                    end
                end
                OP_SUBMIT:
                begin
                    if (!open_reg)
                    begin
                        done = 1'b1;
                    end
                    else if (fill_reg == QFULL)
                    begin
                        em = 1'b1;
                        emw = mk(EV_QUEUE_FULL, 16'd0, 4'd0, 1'b0);
                        emw.last = 1'b1;
                        done = 1'b1;
                    end
                    else if (awaiting_reg)
                    begin
                        done = 1'b1;
                    end
                end
                OP_FRAME:
                begin
                    if (!claim_now || step_reg == 3'd7)
                    begin
                        em = 1'b1;
                        emw = mk(EV_FRAME_STATUS, 16'd0, 4'd0, claim_now);
                        emw.last = 1'b1;
                        done = 1'b1;
                    end
                    else
                    begin
                        case (cur_reg.frame_type)
                            FT_ACK:
                            begin
                                if (step_reg == 3'd1)
                                begin
                                    em = 1'b1;
                                    emw = mk(EV_IDLE, 16'd0, 4'd0, 1'b0);
                                end
                            end
                            FT_NAK:
                            begin
                                if (step_reg == 3'd0 && awaiting_reg)
                                begin
                                    em = 1'b1;
                                    if (retry_inc > {1'b0, max_retries_reg})
                                    begin
                                        emw = mk(EV_NAK_LIMIT, 16'd0, 4'd0, 1'b0);
                                    end
                                    else
                                    begin
                                        emw = mk(EV_REQUEST, peer_reg, iseq_reg, 1'b0);
                                        {emw.out_kind, emw.out_mem_addr, emw.out_count,
                                         emw.out_object_index, emw.out_property_id,
                                         emw.out_start_index, emw.out_payload_tag} =
                                            inflight_reg;
                                    end
                                end
                                else if (step_reg != 3'd0)
                                begin
                                    em = 1'b1;
                                    emw = (step_reg == 3'd1) ?
                                        mk(EV_DISCONNECT, peer_reg, 4'd0, 1'b0) :
                                        mk(EV_CLOSED, 16'd0, 4'd0, 1'b0);
                                end
                            end
                            FT_DISC:
                            begin
                                em = 1'b1;
                                emw = mk(EV_CLOSED, 16'd0, 4'd0, 1'b0);
                            end
                            FT_DATA:
                            begin
                                em = 1'b1;
                                emw = (step_reg == 3'd0) ?
                                    mk(EV_ACK, peer_reg, cur_reg.frame_seq, 1'b0) :
                                    mk(EV_DATA, 16'd0, 4'd0, 1'b0);
                            end
                            default: ;
                        endcase
                    end
                end
                OP_TICK:
                begin
                    if (timer_reg == 16'd0 || timer_reg != 16'd1 || !awaiting_reg)
                    begin
                        done = 1'b1;
                    end
                    else if (retry_inc > {1'b0, max_retries_reg})
                    begin
                        em = 1'b1;
                        emw = mk(EV_NO_ACK, 16'd0, 4'd0, 1'b0);
                    end
                    else
                    begin
                        em = 1'b1;
                        emw = mk(EV_REQUEST, peer_reg, iseq_reg, 1'b0);
                        {emw.out_kind, emw.out_mem_addr, emw.out_count,
                         emw.out_object_index, emw.out_property_id,
                         emw.out_start_index, emw.out_payload_tag} = inflight_reg;
                        emw.last = 1'b1;
                        done = 1'b1;
                    end
                end
                default:
                begin
                    done = 1'b1;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            max_retries_reg <= MAX_RETRIES_RST;
            ack_timeout_reg <= ACK_TIMEOUT_RST;
            open_reg <= 1'b0;
            awaiting_reg <= 1'b0;
            peer_reg <= '0;
            timer_reg <= '0;
            sseq_reg <= '0;
            rseq_reg <= '0;
            iseq_reg <= '0;
            retry_reg <= '0;
            head_reg <= '0;
            fill_reg <= '0;
            step_reg <= '0;
            claim_reg <= 1'b0;
            orp_reg <= '0;
            owp_reg <= '0;
            ocnt_reg <= '0;
            cur_reg <= '0;
            inflight_reg <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_MAX_RETRIES: max_retries_reg <= cfg_data[3:0];
                    CFG_ACK_TIMEOUT: ack_timeout_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (em)
            begin
                owp_reg <= owp_reg + 2'd1;
            end
            if (pop && !empty)
            begin
                orp_reg <= orp_reg + 2'd1;
            end
            ocnt_reg <= ocnt_reg + {2'b0, em} - {2'b0, pop && !empty};

            case (state_reg)
                S_IDLE:
                begin
                    step_reg <= '0;
                    if (cmd_pop)
                    begin
                        cur_reg <= cmd;
                        state_reg <= S_RUN;
                    end
                end
                S_READ:
                begin
                    state_reg <= S_FETCH;
                end
                S_FETCH:
                begin
                    inflight_reg <= ram_rdata;
                    head_reg <= qinc(head_reg);
                    fill_reg <= fill_reg - 1'b1;
                    iseq_reg <= sseq_reg;
                    awaiting_reg <= 1'b1;
                    retry_reg <= '0;
                    timer_reg <= tload;
                    if (cur_reg.operation == OP_FRAME)
                    begin
                        state_reg <= S_RUN;
                    end
                    else
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_RUN:
                begin
                    step_reg <= step_reg + 3'd1;
                    if (step_reg == 3'd0)
                    begin
                        claim_reg <= claim;
                    end
                    case (cur_reg.operation)
                        OP_OPEN:
                        begin
                            if (!(open_reg && peer_reg == cur_reg.peer_addr))
                            begin
                                if (open_reg)
                                begin
                                    // closing half of a reopen
                                    timer_reg <= '0;
                                    fill_reg <= '0;
                                    head_reg <= '0;
                                    awaiting_reg <= 1'b0;
                                    open_reg <= 1'b0;
                                    cur_reg.operation <= OP_CLOSE;
                                    cur_reg.frame_type <= FT_CONNECT;
                                end
                                else if (step_reg[0] == 1'b0)
                                begin
                                    peer_reg <= cur_reg.peer_addr;
                                    sseq_reg <= '0;
                                    rseq_reg <= '0;
                                    awaiting_reg <= 1'b0;
                                    retry_reg <= '0;
                                    head_reg <= '0;
                                    fill_reg <= '0;
                                end
                                else
                                begin
                                    open_reg <= 1'b1;
                                end
                            end
                        end
                        OP_CLOSE:
                        begin
                            if (open_reg)
                            begin
                                timer_reg <= '0;
                                fill_reg <= '0;
                                head_reg <= '0;
                                awaiting_reg <= 1'b0;
                                open_reg <= 1'b0;
                                cur_reg.frame_type <= FT_ACK;
                            end
                            else if (step_reg != 3'd0 && cur_reg.frame_type == FT_CONNECT)
                            begin
                                cur_reg.operation <= OP_OPEN;
                                step_reg <= '0;
                            end
                        end
                        OP_SUBMIT:
                        begin
                            if (open_reg && fill_reg != QFULL)
                            begin
                                fill_reg <= fill_reg + 1'b1;
                                if (!awaiting_reg)
                                begin
                                    state_reg <= S_READ;
                                end
                            end
                        end
                        OP_FRAME:
                        begin
                            if (claim_now && step_reg != 3'd7)
                            begin
                                case (cur_reg.frame_type)
                                    FT_ACK:
                                    begin
                                        if (step_reg == 3'd0)
                                        begin
                                            if (ack_ok)
                                            begin
                                                timer_reg <= '0;
                                                sseq_reg <= sseq_reg + 4'd1;
                                                awaiting_reg <= 1'b0;
                                                if (fill_reg != '0)
                                                begin
                                                    state_reg <= S_FETCH;
                                                    step_reg <= 3'd7;
                                                end
                                            end
                                            else
                                            begin
                                                step_reg <= 3'd7;
                                            end
                                        end
                                        else
                                        begin
                                            step_reg <= 3'd7;
                                        end
                                    end
                                    FT_NAK:
                                    begin
                                        if (step_reg == 3'd0)
                                        begin
                                            if (!awaiting_reg)
                                            begin
                                                step_reg <= 3'd7;
                                            end
                                            else
                                            begin
                                                retry_reg <= retry_inc;
                                                if (retry_inc > {1'b0, max_retries_reg})
                                                begin
                                                    timer_reg <= '0;
                                                end
                                                else
                                                begin
                                                    timer_reg <= tload;
                                                    step_reg <= 3'd7;
                                                end
                                            end
                                        end
                                        else if (step_reg == 3'd1)
                                        begin
                                            fill_reg <= '0;
                                            head_reg <= '0;
                                            awaiting_reg <= 1'b0;
                                            open_reg <= 1'b0;
                                        end
                                        else
                                        begin
                                            step_reg <= 3'd7;
                                        end
                                    end
                                    FT_DISC:
                                    begin
                                        timer_reg <= '0;
                                        open_reg <= 1'b0;
                                        fill_reg <= '0;
                                        head_reg <= '0;
                                        awaiting_reg <= 1'b0;
                                        step_reg <= 3'd7;
                                    end
                                    FT_DATA:
                                    begin
                                        if (step_reg == 3'd0)
                                        begin
                                            if (cur_reg.frame_seq == rseq_reg)
                                            begin
                                                rseq_reg <= rseq_reg + 4'd1;
                                            end
                                        end
                                        else
                                        begin
                                            step_reg <= 3'd7;
                                        end
                                    end
                                    default:
                                    begin
                                        step_reg <= 3'd7;
                                    end
                                endcase
                            end
                        end
                        OP_TICK:
                        begin
                            if (timer_reg != 16'd0)
                            begin
                                timer_reg <= timer_reg - 16'd1;
                                if (timer_reg == 16'd1 && awaiting_reg)
                                begin
                                    retry_reg <= retry_inc;
                                    if (retry_inc > {1'b0, max_retries_reg})
                                    begin
                                        awaiting_reg <= 1'b0;
                                        cur_reg.operation <= OP_CLOSE;
                                    end
                                    else
                                    begin
                                        timer_reg <= tload;
                                    end
                                end
                            end
                        end
                        default: ;
                    endcase
                    if (done)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end
endmodule
`default_nettype wire
